// File: hdl/kiss_urgent_stop_frame_detector_macros.svh
// Assertion helpers used by the checker module kusfd_back.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef KISS_URGENT_STOP_FRAME_DETECTOR_MACROS_SVH
`define KISS_URGENT_STOP_FRAME_DETECTOR_MACROS_SVH

// Check at every rising edge outside reset.
`define KUSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check at every rising edge, reset included.
`define KUSFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: hdl/kusfd_pkg.sv
`default_nettype none

package kusfd_pkg;

  // KISS framing bytes
  localparam logic [7:0] FRAME_END = 8'hC0;
  localparam logic [7:0] FRAME_ESC = 8'hDB;
  localparam logic [7:0] TRANS_END = 8'hDC;
  localparam logic [7:0] TRANS_ESC = 8'hDD;

  // Header: command, four vendor bytes, version, message type
  localparam int HEADER_LEN = 7;

  // Default geometry of the frame
  localparam int PAYLOAD_LEN_DEF = 22;
  localparam int FLAG_OFFSET_DEF = 8;

  // Depth of the queues between the stages
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [31:0] VENDOR_TAG_RST       = 32'h4B56_3450;
  localparam logic [7:0]  HARDWARE_COMMAND_RST = 8'h06;
  localparam logic [7:0]  PROTOCOL_VERSION_RST = 8'h01;
  localparam logic [7:0]  MESSAGE_TYPE_RST     = 8'h0D;
  localparam logic [15:0] STOP_FLAG_MASK_RST   = 16'h0002;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VENDOR_TAG       = 3'd0,
    REG_HARDWARE_COMMAND = 3'd1,
    REG_PROTOCOL_VERSION = 3'd2,
    REG_MESSAGE_TYPE     = 3'd3,
    REG_STOP_FLAG_MASK   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] vendor_tag;
    logic [7:0]  hardware_command;
    logic [7:0]  protocol_version;
    logic [7:0]  message_type;
    logic [15:0] stop_flag_mask;
  } cfg_t;

  // Request from the de-framer to the frame checker
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_OPEN = 2'd1,
    OP_DATA = 2'd2,
    OP_BAD  = 2'd3
  } ev_op_e;

  typedef struct packed {
    ev_op_e     op;
    logic [7:0] data;
    logic       last;
  } ev_t;

  // Expected header byte at a decoded position below HEADER_LEN
  function automatic logic [7:0] hdr_byte(cfg_t cfg, logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = cfg.hardware_command;
      3'd1:    b = cfg.vendor_tag[31:24];
      3'd2:    b = cfg.vendor_tag[23:16];
      3'd3:    b = cfg.vendor_tag[15:8];
      3'd4:    b = cfg.vendor_tag[7:0];
      3'd5:    b = cfg.protocol_version;
      default: b = cfg.message_type;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kusfd_fifo.sv
`default_nettype none

module kusfd_fifo
  import kusfd_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LvlW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = (level_q == LvlW'(DEPTH));
  assign empty_o = (level_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (!do_push && do_pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kusfd_front.sv
`default_nettype none

module kusfd_front
  import kusfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic       full_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            ev_push_o,
  output ev_t             ev_o
);

  logic in_frame_q, in_frame_d;
  logic esc_q, esc_d;
  logic has_data_q, has_data_d;
  logic settled_q, settled_d;
  logic accept;
  ev_op_e op;
  logic [7:0] dec_byte;

  assign accept = push_i && !full_i;

  // Strip framing and escapes, classify the byte
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    has_data_d = has_data_q;
    settled_d  = settled_q;
    op         = OP_NONE;
    dec_byte   = data_byte_i;
    if (!settled_q) begin
      if (data_byte_i == FRAME_END) begin
        if (in_frame_q && has_data_q) begin
          settled_d = 1'b1;
        end else begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          has_data_d = 1'b0;
          op         = OP_OPEN;
        end
      end else if (!in_frame_q) begin
        op = OP_NONE;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (data_byte_i == TRANS_END) begin
          dec_byte   = FRAME_END;
          op         = OP_DATA;
          has_data_d = 1'b1;
        end else if (data_byte_i == TRANS_ESC) begin
          dec_byte   = FRAME_ESC;
          op         = OP_DATA;
          has_data_d = 1'b1;
        end else begin
          settled_d = 1'b1;
          op        = OP_BAD;
        end
      end else if (data_byte_i == FRAME_ESC) begin
        esc_d = 1'b1;
      end else begin
        op         = OP_DATA;
        has_data_d = 1'b1;
      end
    end
    // Drop all framing state at the end of the buffer
    if (last_byte_i) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      has_data_d = 1'b0;
      settled_d  = 1'b0;
    end
  end

  assign ev_push_o = accept && ((op != OP_NONE) || last_byte_i);
  assign ev_o      = '{op: op, data: dec_byte, last: last_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      has_data_q <= 1'b0;
      settled_q  <= 1'b0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      has_data_q <= has_data_d;
      settled_q  <= settled_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kusfd_back.sv
`default_nettype none

module kusfd_back
  import kusfd_pkg::*;
#(
  parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF,
  parameter int FLAG_OFFSET = FLAG_OFFSET_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic ev_empty_i,
  input  wire ev_t  ev_i,
  output logic      ev_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output logic      res_o
);

  `include "kiss_urgent_stop_frame_detector_macros.svh"

  localparam int TotalLen = HEADER_LEN + PAYLOAD_LEN;
  localparam int FlagPos  = HEADER_LEN + FLAG_OFFSET;
  localparam int CntW     = $clog2(TotalLen + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [15:0]     flag_q, flag_d;
  logic            false_q, false_d;
  logic            verdict;

  // Take a request unless its verdict cannot be queued
  assign ev_pop_o   = !ev_empty_i && (!ev_i.last || !res_full_i);
  assign res_push_o = ev_pop_o && ev_i.last;

  // Apply the request, then judge and clear at the end of the buffer
  always_comb begin
    cnt_d    = cnt_q;
    hdr_ok_d = hdr_ok_q;
    flag_d   = flag_q;
    false_d  = false_q;
    case (ev_i.op)
      OP_OPEN: begin
        cnt_d    = '0;
        hdr_ok_d = 1'b1;
        flag_d   = '0;
      end
      OP_DATA: begin
        if (cnt_q == CntW'(TotalLen)) begin
          false_d = 1'b1;
        end else begin
          if ((int'(cnt_q) < HEADER_LEN) &&
              (ev_i.data != hdr_byte(cfg_i, cnt_q[2:0]))) begin
            hdr_ok_d = 1'b0;
          end
          if (int'(cnt_q) == FlagPos) begin
            flag_d[7:0] = ev_i.data;
          end
          if (int'(cnt_q) == FlagPos + 1) begin
            flag_d[15:8] = ev_i.data;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_BAD: begin
        false_d = 1'b1;
      end
      default: begin
        false_d = false_q;
      end
    endcase
    verdict = !false_d && (cnt_d == CntW'(TotalLen)) && hdr_ok_d &&
              ((flag_d & cfg_i.stop_flag_mask) == '0);
    if (ev_i.last) begin
      cnt_d    = '0;
      hdr_ok_d = 1'b1;
      flag_d   = '0;
      false_d  = 1'b0;
    end
  end

  assign res_o = verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      hdr_ok_q <= 1'b1;
      flag_q   <= '0;
      false_q  <= 1'b0;
    end else if (ev_pop_o) begin
      cnt_q    <= cnt_d;
      hdr_ok_q <= hdr_ok_d;
      flag_q   <= flag_d;
      false_q  <= false_d;
    end
  end

  `KUSFD_ASSERT(a_res_only_on_last, res_push_o |-> ev_i.last, "verdict without last byte")
  `KUSFD_ASSERT(a_cnt_bounded, cnt_q <= CntW'(TotalLen), "decoded count past frame length")
  `KUSFD_ASSERT(a_clear, res_push_o |=> (cnt_q == '0) && hdr_ok_q && !false_q, "state kept")
  `KUSFD_ASSERT_ALWAYS(a_reset_state, !rst_ni |-> (cnt_q == '0) && !false_q, "reset state lost")

endmodule

`default_nettype wire

// File: hdl/kiss_urgent_stop_frame_detector.sv
// Accepts one raw byte per cycle while the request queue is not full; the de-framer
// and checker never stall unless the result queue is full. The verdict of a buffer
// passes from the request queue through the checker into the result queue and onto
// the result ports for popping. Throughput is one byte per cycle unless stalled.
// Reset is asynchronous, active low; registers return to their defaults, both queues
// empty, and the block can accept bytes as soon as reset is released.
`default_nettype none

module kiss_urgent_stop_frame_detector
  import kusfd_pkg::*;
#(
  parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF,
  parameter int FLAG_OFFSET = FLAG_OFFSET_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_byte_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       urgent_stop_o
);

  cfg_t cfg_q;
  logic ev_push, ev_empty, ev_pop;
  ev_t  ev_in, ev_out;
  logic res_full, res_push, res_bit;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vendor_tag       <= VENDOR_TAG_RST;
      cfg_q.hardware_command <= HARDWARE_COMMAND_RST;
      cfg_q.protocol_version <= PROTOCOL_VERSION_RST;
      cfg_q.message_type     <= MESSAGE_TYPE_RST;
      cfg_q.stop_flag_mask   <= STOP_FLAG_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VENDOR_TAG:       cfg_q.vendor_tag       <= cfg_wdata_i;
        REG_HARDWARE_COMMAND: cfg_q.hardware_command <= cfg_wdata_i[7:0];
        REG_PROTOCOL_VERSION: cfg_q.protocol_version <= cfg_wdata_i[7:0];
        REG_MESSAGE_TYPE:     cfg_q.message_type     <= cfg_wdata_i[7:0];
        REG_STOP_FLAG_MASK:   cfg_q.stop_flag_mask   <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  kusfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .ev_push_o  (ev_push),
    .ev_o       (ev_in)
  );

  kusfd_fifo #(
    .WIDTH($bits(ev_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ev_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_push),
    .data_i (ev_in),
    .full_o (full),
    .pop_i  (ev_pop),
    .data_o (ev_out),
    .empty_o(ev_empty)
  );

  kusfd_back #(
    .PAYLOAD_LEN(PAYLOAD_LEN),
    .FLAG_OFFSET(FLAG_OFFSET)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .ev_empty_i(ev_empty),
    .ev_i      (ev_out),
    .ev_pop_o  (ev_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_bit)
  );

  kusfd_fifo #(
    .WIDTH(1),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_bit),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (urgent_stop_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire

// File: dv/kiss_urgent_stop_frame_detector_tb.sv
`timescale 1ns / 1ps

module kiss_urgent_stop_frame_detector_tb;
  import kusfd_pkg::*;

  localparam int FRAME_LEN     = HEADER_LEN + PAYLOAD_LEN_DEF;
  localparam int FLAG_AT       = HEADER_LEN + FLAG_OFFSET_DEF;
  localparam int NO_BAD_ESC    = -1;
  localparam int TARGET_BYTES  = 800;
  localparam int PHASE_BUFFERS = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_BURST    = 24;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int QUIET_LIMIT   = 2000;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_IDX_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST         = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  push;
  logic                  full;
  logic [7:0]            data_byte_i;
  logic                  last_byte_i;
  logic                  empty;
  logic                  pop;
  logic                  urgent_stop_o;

  kiss_urgent_stop_frame_detector #(
    .PAYLOAD_LEN(PAYLOAD_LEN_DEF),
    .FLAG_OFFSET(FLAG_OFFSET_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .empty        (empty),
    .pop          (pop),
    .urgent_stop_o(urgent_stop_o)
  );

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic cfg_t default_config();
    cfg_t c;
    c.vendor_tag       = VENDOR_TAG_RST;
    c.hardware_command = HARDWARE_COMMAND_RST;
    c.protocol_version = PROTOCOL_VERSION_RST;
    c.message_type     = MESSAGE_TYPE_RST;
    c.stop_flag_mask   = STOP_FLAG_MASK_RST;
    return c;
  endfunction

  // Header byte that a frame must carry at decoded position pos
  function automatic logic [7:0] hdr_field(cfg_t c, int pos);
    case (pos)
      0:       return c.hardware_command;
      1:       return c.vendor_tag[31:24];
      2:       return c.vendor_tag[23:16];
      3:       return c.vendor_tag[15:8];
      4:       return c.vendor_tag[7:0];
      5:       return c.protocol_version;
      default: return c.message_type;
    endcase
  endfunction

  // Verdict predictor and store of the verdicts still owed by the block
  class verdict_scoreboard;
    cfg_t        regs;
    bit          in_frame;
    bit          esc_pending;
    bit          hdr_ok;
    bit          settled;
    bit          rejected;
    int          dec_count;
    logic [15:0] flag_word;
    bit          verdicts_due[$];
    int          errors;
    int          checked;

    function new();
      regs    = default_config();
      errors  = 0;
      checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      hdr_ok      = 1'b1;
      settled     = 1'b0;
      rejected    = 1'b0;
      dec_count   = 0;
      flag_word   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_VENDOR_TAG:       regs.vendor_tag       = val;
        REG_HARDWARE_COMMAND: regs.hardware_command = val[7:0];
        REG_PROTOCOL_VERSION: regs.protocol_version = val[7:0];
        REG_MESSAGE_TYPE:     regs.message_type     = val[7:0];
        REG_STOP_FLAG_MASK:   regs.stop_flag_mask   = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Count one decoded byte; a byte beyond the frame rejects it
    function void store_decoded(logic [7:0] b);
      if (dec_count >= FRAME_LEN) begin
        settled  = 1'b1;
        rejected = 1'b1;
        return;
      end
      if (dec_count < HEADER_LEN && b != hdr_field(regs, dec_count))
        hdr_ok = 1'b0;
      if (dec_count == FLAG_AT)
        flag_word[7:0] = b;
      if (dec_count == FLAG_AT + 1)
        flag_word[15:8] = b;
      dec_count++;
    endfunction

    // De-frame one raw byte
    function void absorb_byte(logic [7:0] b);
      logic [7:0] d;
      d = b;
      if (b == FRAME_END) begin
        if (in_frame && dec_count > 0) begin
          settled = 1'b1;
        end else begin
          in_frame    = 1'b1;
          esc_pending = 1'b0;
          dec_count   = 0;
          hdr_ok      = 1'b1;
          flag_word   = '0;
        end
        return;
      end
      if (!in_frame)
        return;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == TRANS_END) begin
          d = FRAME_END;
        end else if (b == TRANS_ESC) begin
          d = FRAME_ESC;
        end else begin
          settled  = 1'b1;
          rejected = 1'b1;
          return;
        end
      end else if (b == FRAME_ESC) begin
        esc_pending = 1'b1;
        return;
      end
      store_decoded(d);
    endfunction

    // Note an accepted request; the last byte of a buffer owes a verdict
    function void note_request(logic [7:0] b, logic lst);
      bit ok;
      if (!settled)
        absorb_byte(b);
      if (lst) begin
        ok = !rejected && dec_count == FRAME_LEN && hdr_ok &&
             (flag_word & regs.stop_flag_mask) == '0;
        verdicts_due.push_back(ok);
        clear_frame();
      end
    endfunction

    function void check_verdict(logic v);
      bit want;
      checked++;
      if (verdicts_due.size() == 0) begin
        $error("urgent_stop: result with no verdict pending, actual %0b", v);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (v !== want) begin
        $error("urgent_stop mismatch: expected %0b, actual %0b", want, v);
        errors++;
      end
    endfunction
  endclass

  verdict_scoreboard sb;
  cfg_t              active_cfg;
  logic [7:0]        wire_bytes[$];
  bit                no_idle  = 1'b0;
  bit                hold_req = 1'b0;
  int                used_bytes = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic lst);
    while (!no_idle && chance(25)) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (full);
    sb.note_request(b, lst);
    used_bytes++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < wire_bytes.size(); i++)
      push_byte(wire_bytes[i], i == wire_bytes.size() - 1);
    wire_bytes.delete();
  endtask

  // Stop offering and wait until every verdict has come back
  task automatic drain_verdicts();
    push <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(input cfg_t c, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx;
    if (poke_unused) begin
      idx = CFG_IDX_W'($urandom_range(REG_IDX_FIRST_UNUSED, REG_IDX_LAST));
      write_reg(idx, $urandom);
    end
    write_reg(REG_VENDOR_TAG, c.vendor_tag);
    write_reg(REG_HARDWARE_COMMAND, {24'b0, c.hardware_command});
    write_reg(REG_PROTOCOL_VERSION, {24'b0, c.protocol_version});
    write_reg(REG_MESSAGE_TYPE, {24'b0, c.message_type});
    write_reg(REG_STOP_FLAG_MASK, {16'b0, c.stop_flag_mask});
    cfg_we_i   <= 1'b0;
    active_cfg = c;
  endtask

  // Bytes biased toward the framing codes
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return FRAME_END;
      1:       return FRAME_ESC;
      2:       return TRANS_END;
      3:       return TRANS_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] hdr_choice();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return FRAME_END;
      3:       return FRAME_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    if (chance(25))
      return default_config();
    c.vendor_tag       = {hdr_choice(), hdr_choice(), hdr_choice(), hdr_choice()};
    c.hardware_command = hdr_choice();
    c.protocol_version = hdr_choice();
    c.message_type     = hdr_choice();
    case ($urandom_range(0, 3))
      0:       c.stop_flag_mask = '0;
      1:       c.stop_flag_mask = '1;
      2:       c.stop_flag_mask = 16'h1 << $urandom_range(0, 15);
      default: c.stop_flag_mask = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return c;
  endfunction

  // Escape one decoded byte onto the wire
  function automatic void put_decoded(logic [7:0] b);
    if (b == FRAME_END) begin
      wire_bytes.push_back(FRAME_ESC);
      wire_bytes.push_back(TRANS_END);
    end else if (b == FRAME_ESC) begin
      wire_bytes.push_back(FRAME_ESC);
      wire_bytes.push_back(TRANS_ESC);
    end else begin
      wire_bytes.push_back(b);
    end
  endfunction

  // Build and send one buffer around a frame of len decoded bytes
  task automatic send_frame(input int len, input bit hdr_good, input bit flags_clear,
                            input bit lead_junk, input bit reopen, input bit close_fend,
                            input bit trail, input int bad_esc_at, input bit esc_tail);
    logic [15:0] flags;
    logic [7:0]  b;
    logic [7:0]  flip;
    int          bad_hdr;
    if (lead_junk) begin
      repeat ($urandom_range(1, 4)) begin
        do b = noise_byte(); while (b == FRAME_END);
        wire_bytes.push_back(b);
      end
    end
    wire_bytes.push_back(FRAME_END);
    if (reopen)
      wire_bytes.push_back(FRAME_END);
    flags = 16'($urandom_range(0, 16'hFFFF));
    if (flags_clear)
      flags &= ~active_cfg.stop_flag_mask;
    else
      flags |= active_cfg.stop_flag_mask & ~(active_cfg.stop_flag_mask - 16'h1);
    bad_hdr = hdr_good ? NO_BAD_ESC : $urandom_range(0, HEADER_LEN - 1);
    for (int i = 0; i < len; i++) begin
      if (i == bad_esc_at) begin
        wire_bytes.push_back(FRAME_ESC);
        do b = 8'($urandom_range(0, 255));
        while (b == TRANS_END || b == TRANS_ESC || b == FRAME_END);
        wire_bytes.push_back(b);
      end
      if (i < HEADER_LEN)
        b = hdr_field(active_cfg, i);
      else if (i == FLAG_AT)
        b = flags[7:0];
      else if (i == FLAG_AT + 1)
        b = flags[15:8];
      else
        b = noise_byte();
      if (i == bad_hdr) begin
        flip = 8'($urandom_range(1, 255));
        b ^= flip;
      end
      put_decoded(b);
    end
    if (esc_tail)
      wire_bytes.push_back(FRAME_ESC);
    if (close_fend)
      wire_bytes.push_back(FRAME_END);
    if (trail)
      repeat ($urandom_range(1, 5)) wire_bytes.push_back(noise_byte());
    send_buffer();
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic random_buffer();
    int r;
    int len;
    bit close_fend;
    r = $urandom_range(0, 99);
    close_fend = chance(60);
    if (r < 60) begin
      send_frame(FRAME_LEN, chance(90), chance(75), chance(20), chance(10), close_fend,
                 close_fend && chance(30), NO_BAD_ESC, chance(10));
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       len = FRAME_LEN - 1;
        1:       len = FRAME_LEN + 1;
        2:       len = FRAME_LEN + $urandom_range(2, 4);
        default: len = $urandom_range(0, FRAME_LEN - 2);
      endcase
      send_frame(len, chance(90), chance(75), chance(20), chance(10), close_fend,
                 chance(20), NO_BAD_ESC, chance(10));
    end else if (r < 85) begin
      send_frame(FRAME_LEN, 1'b1, 1'b1, chance(20), 1'b0, close_fend, chance(20),
                 $urandom_range(0, FRAME_LEN - 1), 1'b0);
    end else begin
      repeat ($urandom_range(1, 8)) wire_bytes.push_back(noise_byte());
      send_buffer();
    end
  endtask

  // Result side: pop at random, hold off for a long stretch on request
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_verdict(urgent_stop_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || chance(75);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    int   phase;
    sb          = new();
    active_cfg  = default_config();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases under the reset settings
    send_frame(FRAME_LEN, 1, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 0, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 1, 1, 1, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 0, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 1, 1, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 1, 0, FLAG_AT, 0);
    send_frame(FRAME_LEN + 1, 1, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN - 1, 1, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 0, 0, NO_BAD_ESC, 1);
    send_frame(FRAME_LEN, 0, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    push_byte(FRAME_END, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);

    // Register extremes, then header bytes that need escaping
    drain_verdicts();
    c = '0;
    apply_config(c, 1'b0);
    send_frame(FRAME_LEN, 1, 0, 0, 0, 1, 0, NO_BAD_ESC, 0);
    drain_verdicts();
    c = '1;
    apply_config(c, 1'b0);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 0, 0, 0, 1, 0, NO_BAD_ESC, 0);
    drain_verdicts();
    c.vendor_tag       = {FRAME_END, FRAME_ESC, TRANS_END, TRANS_ESC};
    c.hardware_command = FRAME_END;
    c.protocol_version = FRAME_ESC;
    c.message_type     = TRANS_END;
    c.stop_flag_mask   = 16'h8001;
    apply_config(c, 1'b1);
    send_frame(FRAME_LEN, 1, 1, 0, 0, 1, 0, NO_BAD_ESC, 0);
    send_frame(FRAME_LEN, 1, 0, 0, 0, 0, 0, NO_BAD_ESC, 0);

    // Random phases, each under its own settings
    phase = 0;
    while (phase < 3 || used_bytes < TARGET_BYTES) begin
      drain_verdicts();
      apply_config(random_config(), chance(30));
      no_idle = (phase == 2);
      if (phase == 1) begin
        // Stall the result side while one-byte buffers fill the block
        hold_req = 1'b1;
        repeat (HOLD_BURST) push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      repeat (PHASE_BUFFERS) random_buffer();
      phase++;
    end
    no_idle = 1'b0;

    drain_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
